[src/gpcm_pkg.sv]
// Shared constants and types of the gravity pose cone match unit.
// Used by gpcm_sqrt, the top level, the port checker and the testbench; depends on nothing.
package gpcm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int CFG_W       = 16;
  localparam int CONE_W      = 15;
  localparam int SCORE_W     = 16;
  localparam int FRAC_Q14    = 14;
  localparam int FRAC_Q15    = 15;

  localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
  localparam int PROD_W = SAMPLE_BITS + CFG_W;
  localparam int SUM_W  = 2 * SAMPLE_BITS;
  localparam int DOT_W  = PROD_W + 2;
  localparam int MAG_W  = DOT_W - 1;
  localparam int RAD_W  = SUM_W + FRAC_Q14;
  localparam int ROOT_W = (RAD_W + 1) / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int NUM_W  = MAG_W + 7;
  localparam int QUO_W  = NUM_W - 15;
  localparam int DREM_W = ROOT_W + 1;
  localparam int COS_W  = QUO_W + 1;
  localparam int DIFF_W = QUO_W + 2;
  localparam int DEN_W  = 16;
  localparam int SQB_W  = FRAC_Q15;

  localparam logic [SUM_W-1:0]   MIN_MAG_SQ = SUM_W'(65536);
  localparam logic [SCORE_W-1:0] ONE_Q15    = SCORE_W'(32768);
  localparam logic [DEN_W:0]     ONE_Q14    = (DEN_W + 1)'(16384);

  localparam logic signed [CFG_W-1:0]  RST_CANON_X = '0;
  localparam logic signed [CFG_W-1:0]  RST_CANON_Y = '0;
  localparam logic signed [CFG_W-1:0]  RST_CANON_Z = CFG_W'(16384);
  localparam logic signed [CONE_W-1:0] RST_CONE    = CONE_W'(14189);
  localparam logic [CFG_W-1:0]         RST_LEVEL   = CFG_W'(16384);

  localparam int IN_W  = 3 * SAMPLE_BITS;
  localparam int OUT_W = ((SCORE_W + 1 + 7) / 8) * 8;

  typedef enum logic [2:0] {
    REG_CANON_X = 3'd0,
    REG_CANON_Y = 3'd1,
    REG_CANON_Z = 3'd2,
    REG_CONE    = 3'd3,
    REG_LEVEL   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic             low_mag;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } side_t;

endpackage

[src/gpcm_sqrt.sv]
// Pipelined integer square root, one result bit per stage, with a sideband.
// Depends on gpcm_pkg.
module gpcm_sqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [gpcm_pkg::RAD_W-1:0]     in_rad,
  input  gpcm_pkg::side_t                in_side,
  output logic                           out_valid,
  output logic [gpcm_pkg::ROOT_W-1:0]    out_root,
  output gpcm_pkg::side_t                out_side
);

  localparam int N  = gpcm_pkg::ROOT_W;
  localparam int RW = gpcm_pkg::REM_W;
  localparam int DW = 2 * N;

  logic                vld_r  [N];
  logic [RW-1:0]       rem_r  [N];
  logic [N-1:0]        root_r [N];
  logic [DW-1:0]       rad_r  [N];
  gpcm_pkg::side_t     side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                prv_vld;
    logic [RW-1:0]       prv_rem;
    logic [N-1:0]        prv_root;
    logic [DW-1:0]       prv_rad;
    gpcm_pkg::side_t     prv_side;
    logic [RW-1:0]       rem_t;
    logic [RW-1:0]       trial;
    logic [RW-1:0]       rem_nxt;
    logic [N-1:0]        root_nxt;

    if (k == 0) begin : g_first
      assign prv_vld  = in_valid;
      assign prv_rem  = '0;
      assign prv_root = '0;
      assign prv_rad  = DW'(in_rad);
      assign prv_side = in_side;
    end else begin : g_next
      assign prv_vld  = vld_r[k-1];
      assign prv_rem  = rem_r[k-1];
      assign prv_root = root_r[k-1];
      assign prv_rad  = rad_r[k-1];
      assign prv_side = side_r[k-1];
    end

    always_comb begin
      rem_t = {prv_rem[RW-3:0], prv_rad[DW-1 -: 2]};
      trial = RW'({prv_root, 2'b01});
      if (rem_t >= trial) begin
        rem_nxt  = rem_t - trial;
        root_nxt = {prv_root[N-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_t;
        root_nxt = {prv_root[N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= prv_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        rad_r[k]  <= {prv_rad[DW-3:0], 2'b00};
        side_r[k] <= prv_side;
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

[src/gravity_pose_cone_match_unit.sv]
// Gravity pose cone match: top level with product, divide and score stages.
// Depends on gpcm_pkg and gpcm_sqrt.
//
// Usage:
//   in_*   : one accelerometer gravity sample per beat (x, y, z, signed).
//   out_*  : one result per sample: pose_found and match_score (Q1.15).
//   cfg_*  : write-only registers, canonical vector, cone cosine, match
//            level; write only while no sample is in flight.
// Pipeline: 2 product/sum stages, 23 root stages, 25 quotient stages,
//   1 setup stage, 15 score stages and 1 output stage from an accepted
//   input beat to its output beat.
// Throughput: one sample per cycle while out_tready is high or no output
//   beat is held; every stage is a register slice that moves under one shared enable.
// Reset: clears all valid bits and loads the register reset values.
// Stall: while out_tvalid is high and out_tready low the whole pipeline
//   holds; in_tready drops for that cycle and no beat is lost or repeated.
module gravity_pose_cone_match_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [gpcm_pkg::IN_W-1:0]     in_tdata,   // accel_x, accel_y, accel_z
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [gpcm_pkg::OUT_W-1:0]    out_tdata,  // pose_found, match_score, zero pad
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_idx,
  input  logic [gpcm_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int SB = gpcm_pkg::SAMPLE_BITS;
  localparam int QN = gpcm_pkg::QUO_W;
  localparam int SN = gpcm_pkg::SQB_W;
  localparam int DR = gpcm_pkg::DREM_W;
  localparam int RN = gpcm_pkg::ROOT_W;
  localparam int NW = gpcm_pkg::NUM_W;
  localparam int DN = gpcm_pkg::DEN_W;

  logic en;

  logic signed [gpcm_pkg::CFG_W-1:0]  canon_x_r, canon_y_r, canon_z_r;
  logic signed [gpcm_pkg::CONE_W-1:0] cone_r;
  logic [gpcm_pkg::CFG_W-1:0]         level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canon_x_r <= gpcm_pkg::RST_CANON_X;
      canon_y_r <= gpcm_pkg::RST_CANON_Y;
      canon_z_r <= gpcm_pkg::RST_CANON_Z;
      cone_r    <= gpcm_pkg::RST_CONE;
      level_r   <= gpcm_pkg::RST_LEVEL;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        gpcm_pkg::REG_CANON_X: canon_x_r <= cfg_wdata;
        gpcm_pkg::REG_CANON_Y: canon_y_r <= cfg_wdata;
        gpcm_pkg::REG_CANON_Z: canon_z_r <= cfg_wdata;
        gpcm_pkg::REG_CONE:    cone_r    <= cfg_wdata[gpcm_pkg::CONE_W-1:0];
        gpcm_pkg::REG_LEVEL:   level_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // products
  logic signed [SB-1:0] ax, ay, az;
  assign ax = in_tdata[SB-1:0];
  assign ay = in_tdata[2*SB-1:SB];
  assign az = in_tdata[3*SB-1:2*SB];

  logic                                p0_vld_r;
  logic [gpcm_pkg::SQ_W-1:0]           sqx_r, sqy_r, sqz_r;
  logic signed [gpcm_pkg::PROD_W-1:0]  px_r, py_r, pz_r;
  logic signed [2*SB-1:0]              sqx_f, sqy_f, sqz_f;

  assign sqx_f = ax * ax;
  assign sqy_f = ay * ay;
  assign sqz_f = az * az;

  always_ff @(posedge clk) begin
    if (!rst_n) p0_vld_r <= 1'b0;
    else if (en) p0_vld_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r <= sqx_f[gpcm_pkg::SQ_W-1:0];
      sqy_r <= sqy_f[gpcm_pkg::SQ_W-1:0];
      sqz_r <= sqz_f[gpcm_pkg::SQ_W-1:0];
      px_r  <= ax * canon_x_r;
      py_r  <= ay * canon_y_r;
      pz_r  <= az * canon_z_r;
    end
  end

  // sums
  logic                                p1_vld_r;
  logic [gpcm_pkg::SUM_W-1:0]          sum_r;
  logic signed [gpcm_pkg::DOT_W-1:0]   dot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) p1_vld_r <= 1'b0;
    else if (en) p1_vld_r <= p0_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= gpcm_pkg::SUM_W'(sqx_r) + gpcm_pkg::SUM_W'(sqy_r) + gpcm_pkg::SUM_W'(sqz_r);
      dot_r <= gpcm_pkg::DOT_W'(px_r) + gpcm_pkg::DOT_W'(py_r) + gpcm_pkg::DOT_W'(pz_r);
    end
  end

  // root of |a|^2 * 2^14
  gpcm_pkg::side_t             sq_side;
  gpcm_pkg::side_t             rt_side;
  logic                        rt_vld;
  logic [RN-1:0]               rt_root;
  logic [gpcm_pkg::DOT_W-1:0]  dot_abs;

  assign dot_abs         = dot_r[gpcm_pkg::DOT_W-1] ? -dot_r : dot_r;
  assign sq_side.low_mag = sum_r < gpcm_pkg::MIN_MAG_SQ;
  assign sq_side.neg     = dot_r[gpcm_pkg::DOT_W-1];
  assign sq_side.mag     = dot_abs[gpcm_pkg::MAG_W-1:0];

  gpcm_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p1_vld_r),
    .in_rad    ({sum_r, gpcm_pkg::FRAC_Q14'(0)}),
    .in_side   (sq_side),
    .out_valid (rt_vld),
    .out_root  (rt_root),
    .out_side  (rt_side)
  );

  // quotient |dot| * 128 / root, one bit per stage
  logic [NW-1:0] num_full;
  assign num_full = {rt_side.mag, 7'b0};

  logic            dv_vld_r  [QN];
  logic [DR-1:0]   dv_rem_r  [QN];
  logic [QN-1:0]   dv_q_r    [QN];
  logic [QN-1:0]   dv_lo_r   [QN];
  logic [RN-1:0]   dv_m_r    [QN];
  logic            dv_weak_r [QN];
  logic            dv_neg_r  [QN];

  for (genvar k = 0; k < QN; k++) begin : g_div
    logic            pv;
    logic [DR-1:0]   prem;
    logic [QN-1:0]   pq;
    logic [QN-1:0]   plo;
    logic [RN-1:0]   pm;
    logic            pweak, pneg;
    logic [DR-1:0]   rt, rem_nxt;
    logic            qb;

    if (k == 0) begin : g_first
      assign pv    = rt_vld;
      assign prem  = DR'(num_full[NW-1:QN]);
      assign pq    = '0;
      assign plo   = num_full[QN-1:0];
      assign pm    = rt_root;
      assign pweak = rt_side.low_mag;
      assign pneg  = rt_side.neg;
    end else begin : g_next
      assign pv    = dv_vld_r[k-1];
      assign prem  = dv_rem_r[k-1];
      assign pq    = dv_q_r[k-1];
      assign plo   = dv_lo_r[k-1];
      assign pm    = dv_m_r[k-1];
      assign pweak = dv_weak_r[k-1];
      assign pneg  = dv_neg_r[k-1];
    end

    always_comb begin
      rt = {prem[DR-2:0], plo[QN-1]};
      qb = rt >= DR'(pm);
      rem_nxt = qb ? rt - DR'(pm) : rt;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld_r[k] <= 1'b0;
      else if (en) dv_vld_r[k] <= pv;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[k]  <= rem_nxt;
        dv_q_r[k]    <= {pq[QN-2:0], qb};
        dv_lo_r[k]   <= {plo[QN-2:0], 1'b0};
        dv_m_r[k]    <= pm;
        dv_weak_r[k] <= pweak;
        dv_neg_r[k]  <= pneg;
      end
    end
  end

  // score setup
  logic signed [gpcm_pkg::COS_W-1:0]  cos_q;
  logic signed [gpcm_pkg::DIFF_W-1:0] diff;
  logic [DN:0]                        den_f;

  assign cos_q = dv_neg_r[QN-1] ? -$signed({1'b0, dv_q_r[QN-1]})
                                :  $signed({1'b0, dv_q_r[QN-1]});
  assign diff  = gpcm_pkg::DIFF_W'(cos_q) - gpcm_pkg::DIFF_W'(cone_r);
  assign den_f = gpcm_pkg::ONE_Q14 - (DN + 1)'(cone_r);

  logic            st_vld_r;
  logic            st_in_r;
  logic            st_sat_r;
  logic [DN-1:0]   st_rem_r;
  logic [DN-1:0]   den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) st_vld_r <= 1'b0;
    else if (en) st_vld_r <= dv_vld_r[QN-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_in_r  <= !dv_weak_r[QN-1] && (diff > 0);
      st_sat_r <= diff >= $signed(gpcm_pkg::DIFF_W'(den_f));
      st_rem_r <= diff[DN-1:0];
      den_r    <= den_f[DN-1:0];
    end
  end

  // score quotient (cos - cone) * 2^15 / (1 - cone)
  logic            sc_vld_r [SN];
  logic [DN-1:0]   sc_rem_r [SN];
  logic [SN-1:0]   sc_q_r   [SN];
  logic [DN-1:0]   sc_den_r [SN];
  logic            sc_in_r  [SN];
  logic            sc_sat_r [SN];

  for (genvar k = 0; k < SN; k++) begin : g_score
    logic          pv, pin, psat;
    logic [DN-1:0] prem, pden;
    logic [SN-1:0] pq;
    logic [DN:0]   rt;
    logic          qb;
    logic [DN:0]   rem_nxt;

    if (k == 0) begin : g_first
      assign pv   = st_vld_r;
      assign prem = st_rem_r;
      assign pq   = '0;
      assign pden = den_r;
      assign pin  = st_in_r;
      assign psat = st_sat_r;
    end else begin : g_next
      assign pv   = sc_vld_r[k-1];
      assign prem = sc_rem_r[k-1];
      assign pq   = sc_q_r[k-1];
      assign pden = sc_den_r[k-1];
      assign pin  = sc_in_r[k-1];
      assign psat = sc_sat_r[k-1];
    end

    always_comb begin
      rt = {prem, 1'b0};
      qb = rt >= {1'b0, pden};
      rem_nxt = qb ? rt - {1'b0, pden} : rt;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) sc_vld_r[k] <= 1'b0;
      else if (en) sc_vld_r[k] <= pv;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sc_rem_r[k] <= rem_nxt[DN-1:0];
        sc_q_r[k]   <= {pq[SN-2:0], qb};
        sc_den_r[k] <= pden;
        sc_in_r[k]  <= pin;
        sc_sat_r[k] <= psat;
      end
    end
  end

  // output register
  logic [gpcm_pkg::SCORE_W-1:0] score_nxt;
  logic                         found_nxt;
  logic                         out_vld_r;
  logic [gpcm_pkg::SCORE_W-1:0] score_r;
  logic                         found_r;

  always_comb begin
    priority if (!sc_in_r[SN-1]) begin
      score_nxt = '0;
    end else if (sc_sat_r[SN-1]) begin
      score_nxt = gpcm_pkg::ONE_Q15;
    end else begin
      score_nxt = gpcm_pkg::SCORE_W'(sc_q_r[SN-1]);
    end
    found_nxt = (score_nxt != '0) && (score_nxt >= level_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= sc_vld_r[SN-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      score_r <= score_nxt;
      found_r <= found_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = gpcm_pkg::OUT_W'({score_r, found_r});

endmodule

[src/gpcm_chk.sv]
// Port checker for the gravity pose cone match unit, bound to the top level.
// Depends on gpcm_pkg.
module gpcm_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [gpcm_pkg::OUT_W-1:0]  out_tdata
);

  localparam int SW = gpcm_pkg::SCORE_W;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  a_found_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[SW:1] != '0)
    else $error("pose found with zero score");

  a_score_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[SW:1] <= gpcm_pkg::ONE_Q15)
    else $error("score above one");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind gravity_pose_cone_match_unit gpcm_chk u_gpcm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Testbench for gravity_pose_cone_match_unit: random and directed gravity samples
// go through a stalling stream; each result is checked against a score predictor.
// Depends on gpcm_pkg and the unit's RTL.
module tb;

  localparam int        WATCHDOG_LIMIT = 4000;
  localparam int        DRAIN_CYCLES   = 80;
  localparam logic [2:0] IDX_SPARE     = 3'd6;

  typedef struct {
    logic        found;
    logic [15:0] score;
  } pose_result_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [gpcm_pkg::IN_W-1:0]      in_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [gpcm_pkg::OUT_W-1:0]     out_tdata;
  logic                           cfg_we;
  logic [2:0]                     cfg_idx;
  logic [gpcm_pkg::CFG_W-1:0]     cfg_wdata;

  logic [gpcm_pkg::IN_W-1:0]      pending_samples[$];
  pose_result_t         expected_poses[$];
  int                   errors;
  int                   in_gap;
  int                   out_gap;
  bit                   in_burst;
  bit                   out_burst;
  int                   quiet_cycles;

  longint               canon_x;
  longint               canon_y;
  longint               canon_z;
  longint               cone_cos;
  longint unsigned      match_level;

  gravity_pose_cone_match_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic pose_result_t score_sample(logic [gpcm_pkg::IN_W-1:0] beat);
    longint       ax;
    longint       ay;
    longint       az;
    longint       sq;
    longint       dot;
    longint       mag;
    longint       cosv;
    longint       q;
    pose_result_t res;
    ax = longint'($signed(beat[15:0]));
    ay = longint'($signed(beat[31:16]));
    az = longint'($signed(beat[47:32]));
    sq = ax * ax + ay * ay + az * az;
    q = 0;
    if (sq >= 65536) begin
      dot  = ax * canon_x + ay * canon_y + az * canon_z;
      mag  = longint'(root_floor(longint'(sq) * 16384));
      cosv = (dot * 128) / mag;
      if (cosv > cone_cos) begin
        q = ((cosv - cone_cos) * 32768) / (16384 - cone_cos);
        if (q > 32768) q = 32768;
      end
    end
    res.score = q[15:0];
    res.found = (q != 0 && longint'(q) >= longint'(match_level));
    return res;
  endfunction

  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // sample near the canonical direction, scaled by amp, with noise
  function automatic logic [gpcm_pkg::IN_W-1:0] aligned_sample(int amp, int spread);
    longint n;
    n = spread;
    return {clamp16(canon_z * amp / 16384 + $signed($urandom_range(0, 2 * n)) - n),
            clamp16(canon_y * amp / 16384 + $signed($urandom_range(0, 2 * n)) - n),
            clamp16(canon_x * amp / 16384 + $signed($urandom_range(0, 2 * n)) - n)};
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      gpcm_pkg::REG_CANON_X: canon_x = longint'($signed(v));
      gpcm_pkg::REG_CANON_Y: canon_y = longint'($signed(v));
      gpcm_pkg::REG_CANON_Z: canon_z = longint'($signed(v));
      gpcm_pkg::REG_CONE:    cone_cos = longint'($signed(v[14:0]));
      gpcm_pkg::REG_LEVEL:   match_level = v;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_tvalid || expected_poses.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic setup_phase(logic [15:0] cx, logic [15:0] cy, logic [15:0] cz,
                             logic [15:0] cone, logic [15:0] lvl);
    wait_idle();
    write_reg(gpcm_pkg::REG_CANON_X, cx);
    write_reg(gpcm_pkg::REG_CANON_Y, cy);
    write_reg(gpcm_pkg::REG_CANON_Z, cz);
    write_reg(gpcm_pkg::REG_CONE, cone);
    write_reg(gpcm_pkg::REG_LEVEL, lvl);
  endtask

  task automatic queue_random(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55)
        pending_samples.push_back(aligned_sample($urandom_range(300, 32767),
                                                 $urandom_range(0, 3000)));
      else if (r < 65)
        pending_samples.push_back({clamp16($signed($urandom_range(0, 600)) - 300),
                                   clamp16($signed($urandom_range(0, 600)) - 300),
                                   clamp16($signed($urandom_range(0, 600)) - 300)});
      else
        pending_samples.push_back(gpcm_pkg::IN_W'({$urandom, $urandom}));
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_poses.push_back(score_sample(in_tdata));
      if (!in_tvalid || in_tready) begin
        if ($urandom_range(0, 199) == 0) in_burst <= ~in_burst;
        if (in_gap > 0) begin
          in_gap    <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          in_tdata  <= pending_samples.pop_front();
          in_tvalid <= 1'b1;
          in_gap    <= pick_gap(in_burst);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pose_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_poses.size() == 0) begin
          $display("unexpected result beat at %0t", $time);
          errors++;
        end else begin
          want = expected_poses.pop_front();
          if (out_tdata[0] !== want.found)
            report_mismatch("pose_found", out_tdata[0], want.found);
          if (out_tdata[16:1] !== want.score)
            report_mismatch("match_score", out_tdata[16:1], want.score);
          if (out_tdata[gpcm_pkg::OUT_W-1:17] !== '0)
            report_mismatch("pad", out_tdata[gpcm_pkg::OUT_W-1:17], 0);
        end
      end
      if ($urandom_range(0, 199) == 0) out_burst <= ~out_burst;
      if (out_gap > 0) begin
        out_gap    <= out_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_gap    <= pick_gap(out_burst);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    errors      = 0;
    in_burst    = 1'b0;
    out_burst   = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_wdata   = '0;
    canon_x     = 0;
    canon_y     = 0;
    canon_z     = 16384;
    cone_cos    = 14189;
    match_level = 16384;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero, low-magnitude edge, extremes, along and against z
    pending_samples.push_back('0);
    pending_samples.push_back({16'd0, 16'd0, 16'd256});
    pending_samples.push_back({16'd0, 16'd0, 16'd255});
    pending_samples.push_back({16'd0, 16'd0, 16'hff01});
    pending_samples.push_back({16'd256, 16'd0, 16'd0});
    pending_samples.push_back({16'd255, 16'd0, 16'd0});
    pending_samples.push_back({16'h7fff, 16'd0, 16'd0});
    pending_samples.push_back({16'h8000, 16'd0, 16'd0});
    pending_samples.push_back({16'h7fff, 16'h7fff, 16'h7fff});
    pending_samples.push_back({16'h8000, 16'h8000, 16'h8000});
    pending_samples.push_back({16'h7fff, 16'h8000, 16'h7fff});
    pending_samples.push_back({16'd5000, 16'd100, 16'd100});
    pending_samples.push_back({16'd5000, 16'd1500, 16'd1500});
    pending_samples.push_back({16'd5000, 16'd2000, 16'd0});
    pending_samples.push_back({16'hec78, 16'd0, 16'd0});
    queue_random(200);

    // unused index is ignored; unit x axis
    wait_idle();
    write_reg(IDX_SPARE, 16'h1234);
    setup_phase(16'd16384, 16'd0, 16'd0, 16'd0, 16'd0);
    pending_samples.push_back({16'd0, 16'd0, 16'd9000});
    pending_samples.push_back({16'd0, 16'd9000, 16'd9000});
    pending_samples.push_back({16'd0, 16'd0, 16'h8000});
    queue_random(200);

    // negative vector, widest cone, unreachable level
    setup_phase(16'd0, 16'hc000, 16'd0, 16'h4000, 16'hffff);
    queue_random(200);

    // non-unit vector: cosine past one saturates; narrowest cone, full-scale level
    setup_phase(16'd16384, 16'd16384, 16'd16384, 16'h3fff, 16'd32768);
    queue_random(200);

    // width extremes of the vector
    setup_phase(16'h7fff, 16'h8000, 16'h7fff, 16'd8000, 16'd1);
    queue_random(150);

    for (int p = 0; p < 3; p++) begin
      setup_phase($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                  $urandom_range(0, 32768) - 16384, $urandom_range(0, 32767),
                  $urandom_range(0, 33000));
      queue_random(160);
    end

    wait_idle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
